[hw/rtl/assert_macros.svh]
// Assertion macros shared by the checker files.
// Depends on nothing; included by files that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define CHK_IMPLIES(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
    else $error("implication failed");
`define CHK_NEXT(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
    else $error("next-cycle check failed");
`endif

[hw/rtl/pde_pkg.sv]
// Package for the polynomial derivative evaluator: widths, types, helpers.
// Depends on nothing.
package pde_pkg;
  localparam int unsigned NumCoeffs = 8;
  localparam int unsigned NumRegs = 8;
  localparam int unsigned CoefW = 32;
  localparam int unsigned ValW = 48;
  localparam int unsigned MulW = 32;
  localparam int unsigned IdxW = 3;
  localparam int unsigned CntW = 4;
  localparam logic signed [ValW-1:0] SatMax = {1'b0, {(ValW-1){1'b1}}};
  localparam logic signed [ValW-1:0] SatMin = {1'b1, {(ValW-1){1'b0}}};

  typedef enum logic {
    CMD_DERIV = 1'b0,
    CMD_TANGENT = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_HORNER,
    ST_TAN_MUL,
    ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    MAC_IDLE,
    MAC_LO,
    MAC_HI,
    MAC_RND,
    MAC_ADD,
    MAC_DONE
  } mac_phase_e;

  // Clip a wide signed value to the 48-bit range.
  function automatic logic [ValW:0] clip72(input logic signed [71:0] v);
    logic [ValW:0] r;
    if (v > 72'(SatMax)) begin
      r = {1'b1, SatMax};
    end else if (v < 72'(SatMin)) begin
      r = {1'b1, SatMin};
    end else begin
      r = {1'b0, v[ValW-1:0]};
    end
    return r;
  endfunction
endpackage

[hw/rtl/pde_cell.sv]
// One coefficient cell: holds a coefficient, scales it by one integer per step.
// Depends on pde_pkg.
module pde_cell import pde_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  logic signed [CoefW-1:0] coef_i,
  input  logic                   step_i,
  input  logic [CntW-1:0]        mult_i,
  input  logic                   shift_i,
  input  logic signed [ValW-1:0] nbr_i,
  output logic signed [ValW-1:0] val_o,
  output logic                   sat_o
);
  logic signed [ValW-1:0] val_q, val_d;
  logic signed [71:0] prod;
  logic [ValW:0] clp;

  assign prod = 72'(val_q) * $signed({1'b0, mult_i});
  assign clp = clip72(prod);

  always_comb begin
    val_d = val_q;
    sat_o = 1'b0;
    if (load_i) begin
      val_d = ValW'(coef_i);
    end else if (shift_i) begin
      val_d = nbr_i;
    end else if (step_i) begin
      val_d = clp[ValW-1:0];
      sat_o = clp[ValW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
    end else begin
      val_q <= val_d;
    end
  end

  assign val_o = val_q;
endmodule

[hw/rtl/pde_qmac.sv]
// Rounded Q32.16 multiply, clip, add, clip: acc * x + addend, over several cycles.
// A 32 by 32 multiplier forms the product in two halves; done follows LO, HI, RND and ADD.
// Depends on pde_pkg.
module pde_qmac import pde_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic signed [ValW-1:0] acc_i,
  input  logic signed [ValW:0]   x_i,
  input  logic signed [ValW-1:0] add_i,
  output logic                   busy_o,
  output logic                   done_o,
  output logic signed [ValW-1:0] res_o,
  output logic                   sat_o
);
  mac_phase_e ph_q, ph_d;
  logic neg_q, neg_d;
  logic [ValW-1:0] ua_q, ua_d;
  logic [MulW-1:0] ub_q, ub_d;
  logic signed [ValW-1:0] add_q, add_d;
  logic [63:0] plo_q, plo_d, m_q, m_d;
  logic signed [ValW-1:0] prd_q, prd_d, res_q, res_d;
  logic psat_q, psat_d, sat_q, sat_d;
  logic [MulW-1:0] mul_a;
  logic [63:0] mul_p;
  logic signed [71:0] sum;
  logic [ValW:0] clp;

  assign mul_a = (ph_q == MAC_LO) ? ua_q[MulW-1:0] : {16'h0, ua_q[ValW-1:MulW]};
  assign mul_p = 64'(mul_a) * 64'(ub_q);
  assign sum = 72'(prd_q) + 72'(add_q);
  assign clp = clip72(sum);

  always_comb begin
    ph_d = ph_q; neg_d = neg_q; ua_d = ua_q; ub_d = ub_q; add_d = add_q;
    plo_d = plo_q; m_d = m_q; prd_d = prd_q; psat_d = psat_q;
    res_d = res_q; sat_d = sat_q;
    case (ph_q)
      MAC_IDLE: begin
        if (start_i) begin
          neg_d = acc_i[ValW-1] ^ x_i[ValW];
          ua_d = acc_i[ValW-1] ? ValW'(-acc_i) : ValW'(acc_i);
          ub_d = x_i[ValW] ? MulW'(-x_i) : MulW'(x_i);
          add_d = add_i;
          ph_d = MAC_LO;
        end
      end
      MAC_LO: begin
        plo_d = mul_p;
        ph_d = MAC_HI;
      end
      MAC_HI: begin
        m_d = (mul_p << 16) + ((plo_q + 64'h8000) >> 16);
        ph_d = MAC_RND;
      end
      MAC_RND: begin
        psat_d = 1'b0;
        if (neg_q) begin
          if (m_q > 64'h8000_0000_0000) begin
            prd_d = SatMin;
            psat_d = 1'b1;
          end else begin
            prd_d = -$signed(m_q[ValW-1:0]);
          end
        end else if (m_q > 64'(SatMax)) begin
          prd_d = SatMax;
          psat_d = 1'b1;
        end else begin
          prd_d = m_q[ValW-1:0];
        end
        ph_d = MAC_ADD;
      end
      MAC_ADD: begin
        res_d = clp[ValW-1:0];
        sat_d = psat_q | clp[ValW];
        ph_d = MAC_DONE;
      end
      MAC_DONE: begin
        ph_d = MAC_IDLE;
      end
      default: ph_d = MAC_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= MAC_IDLE;
    end else begin
      ph_q <= ph_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d; ua_q <= ua_d; ub_q <= ub_d; add_q <= add_d;
    plo_q <= plo_d; m_q <= m_d; prd_q <= prd_d; psat_q <= psat_d;
    res_q <= res_d; sat_q <= sat_d;
  end

  assign busy_o = (ph_q != MAC_IDLE);
  assign done_o = (ph_q == MAC_DONE);
  assign res_o = res_q;
  assign sat_o = sat_q;
endmodule

[hw/rtl/polynomial_derivative_evaluator_unit.sv]
// Channel   | Signals                                   | Direction
// in        | in_valid_i/in_ready_o, cmd..deriv_order   | input
// out       | out_valid_o/out_ready_i, result, flags    | output
// cfg       | cfg_valid_i/cfg_ready_o, cfg_index/data   | input
// A derivative of order k up to 7 takes k scaling steps, then 7 - k Horner steps in
// the shared multiply-add unit. A tangent runs two evaluations and one more
// multiply-add. A negative or too large order goes straight to the result.
// Reset clears the state register and the coefficients. A stalled result holds the
// block. Depends on pde_pkg, pde_cell, pde_qmac.
module polynomial_derivative_evaluator_unit import pde_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [IdxW:0]           cfg_index_i,
  input  logic [CoefW-1:0]        cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    cmd_i,
  input  logic signed [CoefW-1:0] x_point_i,
  input  logic signed [CoefW-1:0] point_a_i,
  input  logic signed [4:0]       deriv_order_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [ValW-1:0]  result_value_o,
  output logic                    negative_order_o,
  output logic                    saturated_o
);
  logic signed [CoefW-1:0] coef_q [NumRegs];
  state_e st_q, st_d;
  logic cmd_q;
  logic signed [CoefW-1:0] x_q, a_q;
  logic [CntW-1:0] k_q, k_d, cnt_q, cnt_d;
  logic pass_q, pass_d;
  logic signed [ValW-1:0] acc_q, acc_d, fp_q, fp_d;
  logic sat_q, sat_d, neg_q, neg_d;
  logic signed [ValW-1:0] res_q, res_d;
  logic load, step, shift;
  logic signed [ValW-1:0] cval [NumCoeffs];
  logic [NumCoeffs-1:0] csat;
  logic [CntW-1:0] mults [NumCoeffs];
  logic signed [ValW:0] mx;
  logic signed [ValW-1:0] macc, madd, mres;
  logic msat, mstart, mbusy, mdone;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) coef_q[i] <= '0;
    end else if (cfg_valid_i && cfg_index_i < (IdxW+1)'(NumRegs)) begin
      coef_q[cfg_index_i[IdxW-1:0]] <= cfg_data_i;
    end
  end

  // Cell i >= k scales by (i - cnt) while cnt < k; the other cells scale by one.
  for (genvar g = 0; g < NumCoeffs; g++) begin : g_cell
    assign mults[g] = (cnt_q < k_q && CntW'(g) >= k_q) ? CntW'(g) - cnt_q :
                      CntW'(1);
    pde_cell u_cell (
      .clk_i, .rst_ni, .load_i(load), .coef_i(coef_q[g]),
      .step_i(step), .mult_i(mults[g]), .shift_i(shift),
      .nbr_i(g == 0 ? ValW'(0) : cval[(g == 0) ? 0 : g-1]),
      .val_o(cval[g]), .sat_o(csat[g])
    );
  end

  pde_qmac u_mac (
    .clk_i, .rst_ni, .start_i(mstart), .acc_i(macc), .x_i(mx), .add_i(madd),
    .busy_o(mbusy), .done_o(mdone), .res_o(mres), .sat_o(msat)
  );

  always_comb begin
    macc = acc_q;
    madd = cval[NumCoeffs-1];
    mx = (cmd_q == CMD_TANGENT) ? (ValW+1)'(a_q) : (ValW+1)'(x_q);
    if (st_q == ST_TAN_MUL) begin
      macc = fp_q;
      mx = (ValW+1)'(x_q) - (ValW+1)'(a_q);
      madd = acc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q <= k_d; cnt_q <= cnt_d; pass_q <= pass_d; acc_q <= acc_d; fp_q <= fp_d;
    sat_q <= sat_d; neg_q <= neg_d; res_q <= res_d;
    if (in_valid_i && in_ready_o) begin
      cmd_q <= cmd_i; x_q <= x_point_i; a_q <= point_a_i;
    end
  end

  // Shift cells toward the top so the next coefficient sits in the last cell.
  always_comb begin
    st_d = st_q; k_d = k_q; cnt_d = cnt_q; pass_d = pass_q; acc_d = acc_q;
    fp_d = fp_q; sat_d = sat_q; neg_d = neg_q; res_d = res_q;
    load = 1'b0; step = 1'b0; shift = 1'b0; mstart = 1'b0;
    in_ready_o = 1'b0; out_valid_o = 1'b0;
    case (st_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          sat_d = 1'b0; neg_d = 1'b0; cnt_d = '0; pass_d = 1'b0; res_d = '0;
          if (cmd_i == CMD_TANGENT) begin
            k_d = CntW'(1); load = 1'b1; st_d = ST_SCALE;
          end else if (deriv_order_i[4]) begin
            neg_d = 1'b1; st_d = ST_DONE;
          end else if (deriv_order_i >= 5'(NumCoeffs)) begin
            st_d = ST_DONE;
          end else begin
            k_d = deriv_order_i[CntW-1:0]; load = 1'b1; st_d = ST_SCALE;
          end
        end
      end
      ST_SCALE: begin
        if (cnt_q < k_q) begin
          step = 1'b1; cnt_d = cnt_q + 1'b1;
          sat_d = sat_q | (|csat);
        end else begin
          acc_d = cval[NumCoeffs-1]; shift = 1'b1;
          cnt_d = CntW'(NumCoeffs-1); st_d = ST_HORNER;
        end
      end
      ST_HORNER: begin
        if (cnt_q > k_q) begin
          if (mdone) begin
            acc_d = mres; sat_d = sat_q | msat; shift = 1'b1;
            cnt_d = cnt_q - 1'b1;
          end else if (!mbusy) begin
            mstart = 1'b1;
          end
        end else if (cmd_q == CMD_TANGENT && !pass_q) begin
          fp_d = acc_q; pass_d = 1'b1; k_d = '0; cnt_d = '0;
          load = 1'b1; st_d = ST_SCALE;
        end else if (cmd_q == CMD_TANGENT) begin
          st_d = ST_TAN_MUL;
        end else begin
          res_d = acc_q; st_d = ST_DONE;
        end
      end
      ST_TAN_MUL: begin
        if (mdone) begin
          res_d = mres; sat_d = sat_q | msat; st_d = ST_DONE;
        end else if (!mbusy) begin
          mstart = 1'b1;
        end
      end
      ST_DONE: begin
        out_valid_o = 1'b1;
        if (out_ready_i) st_d = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  assign result_value_o = res_q;
  assign negative_order_o = neg_q;
  assign saturated_o = sat_q;
endmodule

[hw/rtl/pde_checker.sv]
// Port-level checker for the evaluator, bound to the top level.
// Depends on pde_pkg and assert_macros.svh.
`include "assert_macros.svh"
module pde_port_checker import pde_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic negative_order_o,
  input logic saturated_o,
  input logic signed [ValW-1:0] result_value_o
);
  `CHK_IMPLIES(a_neg_zero, clk_i, rst_ni, out_valid_o && negative_order_o,
    result_value_o == '0 && !saturated_o)
  `CHK_IMPLIES(a_excl, clk_i, rst_ni, out_valid_o, !in_ready_o)
  `CHK_NEXT(a_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
  `CHK_NEXT(a_acc, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
endmodule

bind polynomial_derivative_evaluator_unit pde_port_checker u_chk (.*);
